FILE: hw/rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// Chirp sample sequencer package
// Shared types, constants and helper functions for the sample sequencer.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int TableDepth = 4096;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int LenW       = 13;
  localparam int CmpW       = (IdxW + 1 > LenW) ? IdxW + 1 : LenW;
  localparam int AttenW     = 13;
  localparam int AddrW      = 5;
  localparam int DataW      = 32;
  localparam int DivSteps   = 16;
  localparam int DivCntW    = $clog2(DivSteps);

  localparam logic [AttenW-1:0] AttenMin   = AttenW'(256);
  localparam logic [AttenW-1:0] AttenMax   = AttenW'(4096);
  localparam logic [7:0]        MidLevel   = 8'h80;
  localparam logic [7:0]        MuteLevel  = 8'h7F;
  localparam logic [3:0]        PhaseStart = 4'd8;
  localparam logic [3:0]        PhaseEnd   = 4'd0;
  localparam logic [3:0]        PhaseBase  = 4'd4;

  typedef enum logic [2:0] {
    RegStartLength  = 3'd0,
    RegMiddleLength = 3'd1,
    RegEndLength    = 3'd2,
    RegRepeatCount  = 3'd3,
    RegBasePitch    = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    StFill,
    StIdle,
    StLoad,
    StDivide,
    StFinish
  } state_e;

  typedef enum logic [1:0] {
    TabStart,
    TabMiddle,
    TabEnd
  } tab_sel_e;

  typedef struct packed {
    logic              mute_request;
    logic              atten_update;
    logic [AttenW-1:0] atten_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pwm_level;
    logic       period_update;
    logic [7:0] timer_period;
    logic       atten_taken;
  } out_word_t;

  typedef struct packed {
    logic [LenW-1:0] start_length;
    logic [LenW-1:0] middle_length;
    logic [LenW-1:0] end_length;
    logic [1:0]      repeat_count;
    logic [7:0]      base_pitch;
  } cfg_t;

  // A zero length, or one beyond the table depth, plays the whole table.
  function automatic logic [CmpW-1:0] eff_len(logic [LenW-1:0] len);
    logic [CmpW-1:0] wide;
    wide = CmpW'(len);
    if ((len == '0) || (wide > CmpW'(TableDepth))) begin
      eff_len = CmpW'(TableDepth);
    end else begin
      eff_len = wide;
    end
  endfunction

  // One memory row holds the end, middle and start samples of one index.
  function automatic logic [23:0] row_image(logic [IdxW-1:0] addr);
    logic [31:0] wide;
    logic [7:0]  r;
    logic [7:0]  mid;
    wide = 32'(addr);
    r    = wide[7:0];
    mid  = r[7] ? {~r[6:0], 1'b0} : {r[6:0], 1'b0};
    row_image = {~r, mid, r};
  endfunction

endpackage

FILE: hw/rtl/chirp_sample_sequencer.sv
// Flow: a word is accepted in the idle state and passes the load state, 16 divider
// steps and the finish state into the output register; finish waits on an output stall.
// The bit-serial attenuation divider holds one word at a time: none enters until idle.
// Reset: asynchronous, active low; afterwards a fill pass writes the sample memory,
// one row per cycle for all TableDepth (4096) rows, and no word is accepted until it ends.
// Configuration writes are taken at any time and read back over the same port.
// ----------------------------------------------------------------------------
// Chirp sample sequencer
// Plays start, middle and end sample tables in order, one sample per input word,
// scales each sample by the held attenuation and reports timer period updates.
// ----------------------------------------------------------------------------
module chirp_sample_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  css_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output css_pkg::out_word_t             out_word_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [css_pkg::AddrW-1:0]      paddr,
  input  logic [css_pkg::DataW-1:0]      pwdata,
  output logic [css_pkg::DataW-1:0]      prdata,
  output logic                           pready
);

  css_pkg::state_e state_q, state_d;
  css_pkg::cfg_t   cfg_q;

  logic [css_pkg::IdxW-1:0]    fill_cnt_q;
  logic [3:0]                  phase_q, phase_d;
  logic [css_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [css_pkg::AttenW-1:0]  atten_q, atten_d;
  logic                        mute_q, mute_d;

  logic [23:0]                 mem [css_pkg::TableDepth];
  logic [23:0]                 row_q;
  css_pkg::tab_sel_e           sel_q, sel_d;

  logic                        pend_upd_q, pend_upd_d;
  logic [7:0]                  pend_period_q, pend_period_d;
  logic                        pend_taken_q;

  logic [15:0]                 dvd_q;
  logic [13:0]                 rem_q;
  logic [css_pkg::DivCntW-1:0] cnt_q;
  logic                        pos_q;
  logic                        out_mute_q;

  logic                        out_valid_q;
  css_pkg::out_word_t          out_word_q;

  logic                        accept;
  logic                        fill_last;
  logic                        div_last;
  logic                        out_free;
  logic                        out_load;
  logic                        cfg_write;

  logic [css_pkg::LenW-1:0]    cur_len;
  logic [css_pkg::CmpW-1:0]    next_idx;
  logic                        wrap;

  logic [7:0]                  sample;
  logic [7:0]                  mag;
  logic [13:0]                 trial;
  logic                        trial_ge;
  logic [7:0]                  quot;
  logic [7:0]                  level;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  assign fill_last = (fill_cnt_q == css_pkg::IdxW'(css_pkg::TableDepth - 1));
  assign div_last  = (cnt_q == css_pkg::DivCntW'(css_pkg::DivSteps - 1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      css_pkg::StFill:   if (fill_last) state_d = css_pkg::StIdle;
      css_pkg::StIdle:   if (in_valid_i) state_d = css_pkg::StLoad;
      css_pkg::StLoad:   state_d = css_pkg::StDivide;
      css_pkg::StDivide: if (div_last) state_d = css_pkg::StFinish;
      css_pkg::StFinish: if (out_free) state_d = css_pkg::StIdle;
      default:           state_d = css_pkg::StFill;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      css_pkg::StIdle:   in_stall_o = 1'b0;
      css_pkg::StFinish: out_load = out_free;
      default:           in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    case (phase_q)
      css_pkg::PhaseStart: begin
        sel_d   = css_pkg::TabStart;
        cur_len = cfg_q.start_length;
      end
      css_pkg::PhaseEnd: begin
        sel_d   = css_pkg::TabEnd;
        cur_len = cfg_q.end_length;
      end
      default: begin
        sel_d   = css_pkg::TabMiddle;
        cur_len = cfg_q.middle_length;
      end
    endcase
    next_idx = css_pkg::CmpW'(idx_q) + css_pkg::CmpW'(1);
    wrap     = (next_idx >= css_pkg::eff_len(cur_len));
    idx_d    = wrap ? '0 : next_idx[css_pkg::IdxW-1:0];

    atten_d = atten_q;
    if (in_word_i.atten_update) begin
      if (in_word_i.atten_value < css_pkg::AttenMin) begin
        atten_d = css_pkg::AttenMin;
      end else if (in_word_i.atten_value > css_pkg::AttenMax) begin
        atten_d = css_pkg::AttenMax;
      end else begin
        atten_d = in_word_i.atten_value;
      end
    end

    phase_d       = phase_q;
    mute_d        = mute_q;
    pend_upd_d    = 1'b0;
    pend_period_d = '0;
    case (sel_d)
      css_pkg::TabStart: begin
        if (!in_word_i.mute_request) mute_d = 1'b0;
        if (wrap) phase_d = css_pkg::PhaseBase + {2'b00, cfg_q.repeat_count};
      end
      css_pkg::TabEnd: begin
        if (in_word_i.mute_request) mute_d = 1'b1;
        if (wrap) phase_d = css_pkg::PhaseStart;
      end
      default: begin
        if (wrap) begin
          phase_d       = phase_q - 4'd1;
          pend_upd_d    = 1'b1;
          pend_period_d = cfg_q.base_pitch - {6'b0, phase_d[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == css_pkg::StFill) begin
      mem[fill_cnt_q] <= css_pkg::row_image(fill_cnt_q);
    end
    if (accept) begin
      row_q <= mem[idx_q];
    end
  end

  always_comb begin
    case (sel_q)
      css_pkg::TabStart: sample = row_q[7:0];
      css_pkg::TabEnd:   sample = row_q[23:16];
      default:           sample = row_q[15:8];
    endcase
    mag      = (sample > css_pkg::MidLevel) ? sample - css_pkg::MidLevel
                                            : css_pkg::MidLevel - sample;
    trial    = {rem_q[12:0], dvd_q[15]};
    trial_ge = (trial >= {1'b0, atten_q});
    quot     = dvd_q[7:0];
    level    = pos_q ? css_pkg::MidLevel + quot : css_pkg::MidLevel - quot;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sel_q         <= sel_d;
      pend_upd_q    <= pend_upd_d;
      pend_period_q <= pend_period_d;
      pend_taken_q  <= in_word_i.atten_update;
      out_mute_q    <= mute_d;
    end
    if (state_q == css_pkg::StLoad) begin
      dvd_q <= {mag, 8'h00};
      rem_q <= '0;
      pos_q <= (sample > css_pkg::MidLevel);
    end else if (state_q == css_pkg::StDivide) begin
      rem_q <= trial_ge ? trial - {1'b0, atten_q} : trial;
      dvd_q <= {dvd_q[14:0], trial_ge};
    end
    if (out_load) begin
      out_word_q.pwm_level     <= out_mute_q ? css_pkg::MuteLevel : level;
      out_word_q.period_update <= pend_upd_q;
      out_word_q.timer_period  <= pend_period_q;
      out_word_q.atten_taken   <= pend_taken_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= css_pkg::StFill;
      fill_cnt_q  <= '0;
      cnt_q       <= '0;
      phase_q     <= css_pkg::PhaseStart;
      idx_q       <= '0;
      atten_q     <= css_pkg::AttenMax;
      mute_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == css_pkg::StFill) fill_cnt_q <= fill_cnt_q + 1'b1;
      if (state_q == css_pkg::StDivide) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (accept) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        atten_q <= atten_d;
        mute_q  <= mute_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_length  <= css_pkg::LenW'(4096);
      cfg_q.middle_length <= css_pkg::LenW'(4096);
      cfg_q.end_length    <= css_pkg::LenW'(4096);
      cfg_q.repeat_count  <= 2'd0;
      cfg_q.base_pitch    <= 8'd63;
    end else if (cfg_write) begin
      case (paddr[4:2])
        css_pkg::RegStartLength:  cfg_q.start_length  <= pwdata[css_pkg::LenW-1:0];
        css_pkg::RegMiddleLength: cfg_q.middle_length <= pwdata[css_pkg::LenW-1:0];
        css_pkg::RegEndLength:    cfg_q.end_length    <= pwdata[css_pkg::LenW-1:0];
        css_pkg::RegRepeatCount:  cfg_q.repeat_count  <= pwdata[1:0];
        css_pkg::RegBasePitch:    cfg_q.base_pitch    <= pwdata[7:0];
        default:                  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      css_pkg::RegStartLength:  prdata = css_pkg::DataW'(cfg_q.start_length);
      css_pkg::RegMiddleLength: prdata = css_pkg::DataW'(cfg_q.middle_length);
      css_pkg::RegEndLength:    prdata = css_pkg::DataW'(cfg_q.end_length);
      css_pkg::RegRepeatCount:  prdata = css_pkg::DataW'(cfg_q.repeat_count);
      css_pkg::RegBasePitch:    prdata = css_pkg::DataW'(cfg_q.base_pitch);
      default:                  prdata = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_atten_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (atten_q >= css_pkg::AttenMin) && (atten_q <= css_pkg::AttenMax))
    else $error("held attenuation left its range");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= css_pkg::PhaseStart)
    else $error("phase counter beyond the start phase");

  a_fill_before_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == css_pkg::StFill) |-> in_stall_o)
    else $error("input open during the memory fill");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == css_pkg::StFinish)
    else $error("result appeared without a finished division");

  a_mute_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_mute_q) |=> out_word_q.pwm_level == css_pkg::MuteLevel)
    else $error("muted word carries a sound level");

endmodule
